// File: rtl/core/waypoint_path_upsampler_top_macros.svh
// Assertion helpers used by the core datapath module.
`ifndef WAYPOINT_PATH_UPSAMPLER_TOP_MACROS_SVH
`define WAYPOINT_PATH_UPSAMPLER_TOP_MACROS_SVH

// Condition must never hold at a clock edge outside reset.
`define WPU_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define WPU_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/wpu_pkg.sv
package wpu_pkg;

    localparam int MAX_FACTOR   = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int FACTOR_W     = 5;
    localparam int STEP_W       = $clog2(MAX_FACTOR);
    localparam int COR_W        = 40;
    localparam int ANG_W        = 34;
    localparam int ITER_W       = $clog2(CORDIC_STEPS);
    localparam int TAB_LEN      = 24;
    localparam int TAB_IDX_W    = $clog2(TAB_LEN);
    localparam int LANE_W       = 33;
    localparam int LANES        = 4;
    localparam int DIV_CNT_W    = $clog2(LANE_W + 1);
    localparam int CFG_ADDR_W   = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_INTERP_FACTOR = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT_Z      = 1'b1;

    // lane assignment of the interpolators
    localparam int LANE_X   = 0;
    localparam int LANE_Y   = 1;
    localparam int LANE_SPD = 2;
    localparam int LANE_YAW = 3;

    // gain-compensated start vector, Q30
    localparam logic signed [COR_W-1:0] ROT_X0 = 40'sd652032874;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURN [TAB_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic capture;
        logic prod;
        logic yaw_start;
        logic yaw_latch;
        logic seg_start;
        logic seg_sel;
        logic rot_start;
        logic load_point;
        logic load_pass;
        logic upd_state;
    } wpu_cmd_t;

    typedef struct packed {
        logic busy;
        logic pass;
        logic store_only;
        logic last_step;
        logic need_wrap;
        logic out_free;
    } wpu_sts_t;

endpackage

// File: rtl/core/wpu_cordic.sv
module wpu_cordic import wpu_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic                     vec_mode,
    input  logic signed [COR_W-1:0]  x0,
    input  logic signed [COR_W-1:0]  y0,
    input  logic signed [ANG_W-1:0]  z0,
    output logic                     busy,
    output logic signed [COR_W-1:0]  x,
    output logic signed [COR_W-1:0]  y,
    output logic signed [ANG_W-1:0]  z
);

    logic signed [COR_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ANG_W-1:0] z_reg, z_next;
    logic [ITER_W-1:0]       iter_reg, iter_next;
    logic                    busy_reg, busy_next;
    logic                    vec_reg, vec_next;
    logic signed [COR_W-1:0] dx, dy;
    logic signed [ANG_W-1:0] da;
    logic                    sigma_pos;

    always_comb begin
        dx        = x_reg >>> iter_reg;
        dy        = y_reg >>> iter_reg;
        da        = $signed({2'b00, ATAN_TURN[TAB_IDX_W'(iter_reg)]});
        // vectoring drives y toward zero, rotation drives z toward zero
        sigma_pos = vec_reg ? !(y_reg > 0) : (z_reg >= 0);
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        iter_next = iter_reg;
        busy_next = busy_reg;
        vec_next  = vec_reg;
        if (start) begin
            x_next    = x0;
            y_next    = y0;
            z_next    = z0;
            iter_next = '0;
            busy_next = 1'b1;
            // hold the mode for the whole run
            vec_next  = vec_mode;
        end else if (busy_reg) begin
            if (sigma_pos) begin
                x_next = x_reg - dy;
                y_next = y_reg + dx;
                z_next = z_reg - da;
            end else begin
                x_next = x_reg + dy;
                y_next = y_reg - dx;
                z_next = z_reg + da;
            end
            iter_next = iter_reg + 1'b1;
            if (iter_reg == ITER_W'(CORDIC_STEPS - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
            vec_reg  <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            iter_reg <= iter_next;
            vec_reg  <= vec_next;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign busy = busy_reg;
    assign x    = x_reg;
    assign y    = y_reg;
    assign z    = z_reg;

endmodule

// File: rtl/core/wpu_datapath.sv
`include "waypoint_path_upsampler_top_macros.svh"

module wpu_datapath import wpu_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [31:0]           cfg_wdata,
    input  logic signed [31:0]    s_pos_x,
    input  logic signed [31:0]    s_pos_y,
    input  logic signed [15:0]    s_quat_x,
    input  logic signed [15:0]    s_quat_y,
    input  logic signed [15:0]    s_quat_z,
    input  logic signed [15:0]    s_quat_w,
    input  logic signed [15:0]    s_speed,
    input  logic                  s_final_waypoint,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [31:0]    m_out_x,
    output logic signed [31:0]    m_out_y,
    output logic signed [31:0]    m_out_z,
    output logic signed [15:0]    m_out_qx,
    output logic signed [15:0]    m_out_qy,
    output logic signed [15:0]    m_out_qz,
    output logic signed [15:0]    m_out_qw,
    output logic signed [15:0]    m_out_speed,
    output logic                  m_run_end,
    output logic                  m_path_end,
    input  wpu_cmd_t              cmd,
    output wpu_sts_t              sts
);

    function automatic logic signed [15:0] to_q14(input logic signed [COR_W-1:0] v,
                                                  input logic neg);
        logic signed [COR_W-1:0]  t;
        logic signed [COR_W-17:0] r;
        t = v + 40'sd32768;
        r = (COR_W-16)'(t >>> 16);
        if (neg) r = -r;
        if (r > 24'sd16384) r = 24'sd16384;
        if (r < -24'sd16384) r = -24'sd16384;
        return 16'(r);
    endfunction

    // configuration
    logic [FACTOR_W-1:0] factor_cfg_reg;
    logic signed [31:0]  height_reg;
    logic [FACTOR_W-1:0] f_reg;

    // current waypoint
    logic signed [31:0] px_reg, py_reg;
    logic signed [15:0] qx_reg, qy_reg, qz_reg, qw_reg, spd_reg, yaw_reg;
    logic               fin_reg, yzero_reg;
    logic signed [31:0] pwz_reg, pxy_reg, pyy_reg, pzz_reg;

    // path memory
    logic signed [31:0] prev_x_reg, prev_y_reg, first_x_reg, first_y_reg;
    logic signed [15:0] prev_spd_reg, prev_yaw_reg, first_spd_reg, first_yaw_reg;
    logic [1:0]         seen_reg;

    // interpolation lanes
    logic                seg_reg;
    logic [LANE_W-1:0]   num_reg [LANES];
    logic [FACTOR_W-1:0] rem_reg [LANES];
    logic                neg_reg [LANES];
    logic [LANE_W-1:0]   q_reg   [LANES];
    logic [FACTOR_W:0]   r_reg   [LANES];
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic                div_busy_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                rneg_reg;

    // output register
    logic               m_valid_reg;
    logic signed [31:0] out_x_reg, out_y_reg, out_z_reg;
    logic signed [15:0] out_qx_reg, out_qy_reg, out_qz_reg, out_qw_reg, out_spd_reg;
    logic               run_end_reg, path_end_reg;

    logic signed [LANE_W-1:0] a_start [LANES];
    logic signed [LANE_W-1:0] b_start [LANES];
    logic signed [LANE_W-1:0] a_base  [LANES];
    logic signed [LANE_W-1:0] d_start [LANES];
    logic [LANE_W-1:0]        mag     [LANES];
    logic signed [LANE_W:0]   lval    [LANES];
    logic [FACTOR_W:0]        rem_sh  [LANES];
    logic                     ge      [LANES];
    logic [FACTOR_W+1:0]      r_sum   [LANES];
    logic                     ge2     [LANES];
    logic signed [15:0]       dyaw;

    logic signed [COR_W-1:0] xs, ys, cx0, cy0;
    logic signed [ANG_W-1:0] cz0, rz;
    logic signed [31:0]      z32;
    logic                    rneg;
    logic                    cor_busy;
    logic signed [COR_W-1:0] cor_x, cor_y;
    logic signed [ANG_W-1:0] cor_z;
    logic [31:0]             ang;
    logic                    out_free, last_step;
    logic [FACTOR_W-1:0]     f_eff;

    always_comb begin
        if (factor_cfg_reg == '0) f_eff = FACTOR_W'(1);
        else if (factor_cfg_reg > FACTOR_W'(MAX_FACTOR)) f_eff = FACTOR_W'(MAX_FACTOR);
        else f_eff = factor_cfg_reg;
    end

    // segment endpoints: sel 0 runs previous -> current, sel 1 current -> first
    always_comb begin
        a_start[LANE_X]   = cmd.seg_sel ? LANE_W'(px_reg)  : LANE_W'(prev_x_reg);
        b_start[LANE_X]   = cmd.seg_sel ? LANE_W'(first_x_reg) : LANE_W'(px_reg);
        a_start[LANE_Y]   = cmd.seg_sel ? LANE_W'(py_reg)  : LANE_W'(prev_y_reg);
        b_start[LANE_Y]   = cmd.seg_sel ? LANE_W'(first_y_reg) : LANE_W'(py_reg);
        a_start[LANE_SPD] = cmd.seg_sel ? LANE_W'(spd_reg) : LANE_W'(prev_spd_reg);
        b_start[LANE_SPD] = cmd.seg_sel ? LANE_W'(first_spd_reg) : LANE_W'(spd_reg);
        a_start[LANE_YAW] = cmd.seg_sel ? LANE_W'(yaw_reg) : LANE_W'(prev_yaw_reg);
        b_start[LANE_YAW] = cmd.seg_sel ? LANE_W'(first_yaw_reg) : LANE_W'(yaw_reg);
        a_base[LANE_X]    = seg_reg ? LANE_W'(px_reg)  : LANE_W'(prev_x_reg);
        a_base[LANE_Y]    = seg_reg ? LANE_W'(py_reg)  : LANE_W'(prev_y_reg);
        a_base[LANE_SPD]  = seg_reg ? LANE_W'(spd_reg) : LANE_W'(prev_spd_reg);
        a_base[LANE_YAW]  = seg_reg ? LANE_W'(yaw_reg) : LANE_W'(prev_yaw_reg);
        // yaw takes the shorter arc
        dyaw = 16'(b_start[LANE_YAW] - a_start[LANE_YAW]);
        for (int k = 0; k < LANES; k++) begin
            if (k == LANE_YAW) d_start[k] = LANE_W'(dyaw);
            else d_start[k] = b_start[k] - a_start[k];
            mag[k]    = d_start[k][LANE_W-1] ? LANE_W'(-d_start[k]) : LANE_W'(d_start[k]);
            lval[k]   = (LANE_W+1)'(a_base[k])
                      + (neg_reg[k] ? -$signed({1'b0, q_reg[k]}) : $signed({1'b0, q_reg[k]}));
            rem_sh[k] = {rem_reg[k], num_reg[k][LANE_W-1]};
            ge[k]     = rem_sh[k] >= {1'b0, f_reg};
            r_sum[k]  = {1'b0, r_reg[k]} + {1'b0, rem_reg[k], 1'b0};
            ge2[k]    = r_sum[k] >= {1'b0, f_reg, 1'b0};
        end
    end

    // yaw setup and half-angle fold
    always_comb begin
        ys  = (COR_W'(pwz_reg) + COR_W'(pxy_reg)) <<< 1;
        xs  = 40'sd268435456 - ((COR_W'(pyy_reg) + COR_W'(pzz_reg)) <<< 1);
        z32 = {lval[LANE_YAW][16:0], 15'b0};
        rz  = ANG_W'(z32);
        rneg = 1'b0;
        if (z32 > 32'sh40000000) begin
            rz   = ANG_W'(z32) - 34'sh080000000;
            rneg = 1'b1;
        end else if (z32 < -32'sh40000000) begin
            rz   = ANG_W'(z32) + 34'sh080000000;
            rneg = 1'b1;
        end
        if (cmd.yaw_start) begin
            cx0 = xs[COR_W-1] ? -xs : xs;
            cy0 = xs[COR_W-1] ? -ys : ys;
            cz0 = xs[COR_W-1] ? 34'sh080000000 : '0;
        end else begin
            cx0 = ROT_X0;
            cy0 = '0;
            cz0 = rz;
        end
        ang = cor_z[31:0] + 32'h8000;
    end

    wpu_cordic u_cordic (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.yaw_start | cmd.rot_start),
        .vec_mode (cmd.yaw_start),
        .x0       (cx0),
        .y0       (cy0),
        .z0       (cz0),
        .busy     (cor_busy),
        .x        (cor_x),
        .y        (cor_y),
        .z        (cor_z)
    );

    assign out_free  = !m_valid_reg || m_ready;
    assign last_step = {1'b0, step_reg} == (f_reg - 1'b1);

    always_comb begin
        sts.busy       = div_busy_reg | cor_busy;
        sts.pass       = (f_reg == FACTOR_W'(1)) || (seen_reg == 2'd0 && fin_reg);
        sts.store_only = seen_reg == 2'd0;
        sts.last_step  = last_step;
        sts.need_wrap  = fin_reg && !seg_reg;
        sts.out_free   = out_free;
    end

    // config and control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            factor_cfg_reg <= FACTOR_W'(5);
            height_reg     <= '0;
            seen_reg       <= 2'd0;
            m_valid_reg    <= 1'b0;
            div_busy_reg   <= 1'b0;
            div_cnt_reg    <= '0;
            first_x_reg    <= '0;
            first_y_reg    <= '0;
            first_spd_reg  <= '0;
            first_yaw_reg  <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            prev_spd_reg   <= '0;
            prev_yaw_reg   <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_INTERP_FACTOR: factor_cfg_reg <= cfg_wdata[FACTOR_W-1:0];
                    REG_HEIGHT_Z:      height_reg     <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.load_point || cmd.load_pass) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
            if (cmd.seg_start) begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= '0;
            end else if (div_busy_reg) begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(LANE_W - 1)) div_busy_reg <= 1'b0;
            end
            if (cmd.upd_state) begin
                if (fin_reg) begin
                    seen_reg <= 2'd0;
                end else begin
                    if (seen_reg == 2'd0) begin
                        first_x_reg   <= px_reg;
                        first_y_reg   <= py_reg;
                        first_spd_reg <= spd_reg;
                        first_yaw_reg <= yaw_reg;
                        seen_reg      <= 2'd1;
                    end else begin
                        seen_reg <= 2'd2;
                    end
                    prev_x_reg   <= px_reg;
                    prev_y_reg   <= py_reg;
                    prev_spd_reg <= spd_reg;
                    prev_yaw_reg <= yaw_reg;
                end
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            px_reg  <= s_pos_x;
            py_reg  <= s_pos_y;
            qx_reg  <= s_quat_x;
            qy_reg  <= s_quat_y;
            qz_reg  <= s_quat_z;
            qw_reg  <= s_quat_w;
            spd_reg <= s_speed;
            fin_reg <= s_final_waypoint;
            f_reg   <= f_eff;
        end
        if (cmd.prod) begin
            pwz_reg <= qw_reg * qz_reg;
            pxy_reg <= qx_reg * qy_reg;
            pyy_reg <= qy_reg * qy_reg;
            pzz_reg <= qz_reg * qz_reg;
        end
        if (cmd.yaw_start) yzero_reg <= (xs == '0) && (ys == '0);
        if (cmd.yaw_latch) yaw_reg <= yzero_reg ? 16'sd0 : $signed(ang[31:16]);
        if (cmd.rot_start) rneg_reg <= rneg;
        if (cmd.seg_start) begin
            seg_reg  <= cmd.seg_sel;
            step_reg <= '0;
        end else if (cmd.load_point) begin
            step_reg <= step_reg + 1'b1;
        end
        for (int k = 0; k < LANES; k++) begin
            if (cmd.seg_start) begin
                num_reg[k] <= mag[k];
                rem_reg[k] <= '0;
                neg_reg[k] <= d_start[k][LANE_W-1];
                q_reg[k]   <= '0;
                r_reg[k]   <= {1'b0, f_reg};
            end else if (div_busy_reg) begin
                // restoring divide, one quotient bit per cycle
                num_reg[k] <= {num_reg[k][LANE_W-2:0], ge[k]};
                rem_reg[k] <= ge[k] ? FACTOR_W'(rem_sh[k] - {1'b0, f_reg})
                                    : rem_sh[k][FACTOR_W-1:0];
            end else if (cmd.load_point) begin
                // advance rounded quotient by one step of the delta
                q_reg[k] <= q_reg[k] + num_reg[k] + LANE_W'(ge2[k]);
                r_reg[k] <= ge2[k] ? (FACTOR_W+1)'(r_sum[k] - {1'b0, f_reg, 1'b0})
                                   : r_sum[k][FACTOR_W:0];
            end
        end
        if (cmd.load_pass) begin
            out_x_reg    <= px_reg;
            out_y_reg    <= py_reg;
            out_z_reg    <= height_reg;
            out_qx_reg   <= qx_reg;
            out_qy_reg   <= qy_reg;
            out_qz_reg   <= qz_reg;
            out_qw_reg   <= qw_reg;
            out_spd_reg  <= spd_reg;
            run_end_reg  <= 1'b1;
            path_end_reg <= fin_reg;
        end else if (cmd.load_point) begin
            out_x_reg    <= lval[LANE_X][31:0];
            out_y_reg    <= lval[LANE_Y][31:0];
            out_z_reg    <= height_reg;
            out_qx_reg   <= '0;
            out_qy_reg   <= '0;
            out_qz_reg   <= to_q14(cor_y, rneg_reg);
            out_qw_reg   <= to_q14(cor_x, rneg_reg);
            out_spd_reg  <= lval[LANE_SPD][15:0];
            run_end_reg  <= last_step && (seg_reg || !fin_reg);
            path_end_reg <= last_step && seg_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_x     = out_x_reg;
    assign m_out_y     = out_y_reg;
    assign m_out_z     = out_z_reg;
    assign m_out_qx    = out_qx_reg;
    assign m_out_qy    = out_qy_reg;
    assign m_out_qz    = out_qz_reg;
    assign m_out_qw    = out_qw_reg;
    assign m_out_speed = out_spd_reg;
    assign m_run_end   = run_end_reg;
    assign m_path_end  = path_end_reg;

    `WPU_ASSERT_NEVER(a_no_overwrite, (cmd.load_point || cmd.load_pass) && !out_free, "output beat overwritten")
    `WPU_ASSERT_NEVER(a_cordic_idle, (cmd.rot_start || cmd.yaw_start) && cor_busy, "cordic restarted while busy")
    `WPU_ASSERT_IMPLY(a_path_run_end, m_valid_reg && path_end_reg, run_end_reg, "path end without run end")
    `WPU_ASSERT_NEVER(a_emit_during_div, cmd.load_point && div_busy_reg, "point emitted before divide done")

endmodule

// File: rtl/core/wpu_ctrl.sv
module wpu_ctrl import wpu_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  wpu_sts_t sts,
    output wpu_cmd_t cmd
);

    typedef enum logic [3:0] {
        IDLE, PROD, SUM, YAW_WAIT, DECIDE, PASS, SEG, DIV_WAIT, POINT, ROT_WAIT, EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            IDLE: begin
                if (s_valid && ready_reg) begin
                    cmd.capture = 1'b1;
                    state_next  = PROD;
                end
            end
            PROD: begin
                cmd.prod   = 1'b1;
                state_next = SUM;
            end
            SUM: begin
                cmd.yaw_start = 1'b1;
                state_next    = YAW_WAIT;
            end
            YAW_WAIT: begin
                if (!sts.busy) begin
                    cmd.yaw_latch = 1'b1;
                    state_next    = DECIDE;
                end
            end
            DECIDE: begin
                if (sts.pass) begin
                    state_next = PASS;
                end else if (sts.store_only) begin
                    cmd.upd_state = 1'b1;
                    state_next    = IDLE;
                end else begin
                    cmd.seg_start = 1'b1;
                    state_next    = DIV_WAIT;
                end
            end
            PASS: begin
                if (sts.out_free) begin
                    cmd.load_pass = 1'b1;
                    cmd.upd_state = 1'b1;
                    state_next    = IDLE;
                end
            end
            SEG: begin
                // wrap segment back to the first waypoint
                cmd.seg_start = 1'b1;
                cmd.seg_sel   = 1'b1;
                state_next    = DIV_WAIT;
            end
            DIV_WAIT: begin
                if (!sts.busy) state_next = POINT;
            end
            POINT: begin
                cmd.rot_start = 1'b1;
                state_next    = ROT_WAIT;
            end
            ROT_WAIT: begin
                if (!sts.busy) state_next = EMIT;
            end
            EMIT: begin
                if (sts.out_free) begin
                    cmd.load_point = 1'b1;
                    if (!sts.last_step) begin
                        state_next = POINT;
                    end else if (sts.need_wrap) begin
                        state_next = SEG;
                    end else begin
                        cmd.upd_state = 1'b1;
                        state_next    = IDLE;
                    end
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= state_next == IDLE;
        end
    end

    assign s_ready = ready_reg;

endmodule

// File: rtl/core/waypoint_path_upsampler_top.sv
// Passthrough: capture, products, sum, 16-step yaw CORDIC, decide, load.
// Interpolation: after the decide, a segment starts the 33-step lane divider, and
// each point is issued to the shared CORDIC (16 steps) and then loaded.
// One item in flight; an interpolated final waypoint adds a wrap segment back to the
// first waypoint. Reset (aresetn low, synchronous): factor 5, height 0, path memory
// cleared, no beat held.
module waypoint_path_upsampler_top import wpu_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [31:0]           cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [31:0]    s_pos_x,
    input  logic signed [31:0]    s_pos_y,
    input  logic signed [15:0]    s_quat_x,
    input  logic signed [15:0]    s_quat_y,
    input  logic signed [15:0]    s_quat_z,
    input  logic signed [15:0]    s_quat_w,
    input  logic signed [15:0]    s_speed,
    input  logic                  s_final_waypoint,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [31:0]    m_out_x,
    output logic signed [31:0]    m_out_y,
    output logic signed [31:0]    m_out_z,
    output logic signed [15:0]    m_out_qx,
    output logic signed [15:0]    m_out_qy,
    output logic signed [15:0]    m_out_qz,
    output logic signed [15:0]    m_out_qw,
    output logic signed [15:0]    m_out_speed,
    output logic                  m_run_end,
    output logic                  m_path_end
);

    wpu_cmd_t cmd;
    wpu_sts_t sts;

    wpu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    wpu_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_pos_x          (s_pos_x),
        .s_pos_y          (s_pos_y),
        .s_quat_x         (s_quat_x),
        .s_quat_y         (s_quat_y),
        .s_quat_z         (s_quat_z),
        .s_quat_w         (s_quat_w),
        .s_speed          (s_speed),
        .s_final_waypoint (s_final_waypoint),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_x          (m_out_x),
        .m_out_y          (m_out_y),
        .m_out_z          (m_out_z),
        .m_out_qx         (m_out_qx),
        .m_out_qy         (m_out_qy),
        .m_out_qz         (m_out_qz),
        .m_out_qw         (m_out_qw),
        .m_out_speed      (m_out_speed),
        .m_run_end        (m_run_end),
        .m_path_end       (m_path_end),
        .cmd              (cmd),
        .sts              (sts)
    );

endmodule

// File: tb/sv/waypoint_path_upsampler_top_test.sv
module waypoint_path_upsampler_top_test;
    import wpu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 800;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [15:0] quat_x;
        logic [15:0] quat_y;
        logic [15:0] quat_z;
        logic [15:0] quat_w;
        logic [15:0] speed;
        logic        final_waypoint;
    } waypoint_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [15:0] qx;
        logic [15:0] qy;
        logic [15:0] qz;
        logic [15:0] qw;
        logic [15:0] spd;
        logic        run_end;
        logic        path_end;
    } point_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [31:0]           cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic signed [31:0]    s_pos_x, s_pos_y;
    logic signed [15:0]    s_quat_x, s_quat_y, s_quat_z, s_quat_w, s_speed;
    logic                  s_final_waypoint;
    logic                  m_valid;
    logic                  m_ready;
    logic signed [31:0]    m_out_x, m_out_y, m_out_z;
    logic signed [15:0]    m_out_qx, m_out_qy, m_out_qz, m_out_qw, m_out_speed;
    logic                  m_run_end, m_path_end;

    waypoint_path_upsampler_top u_dut (.*);

    // shadow of the block's registers and path memory
    logic [4:0]  factor_reg;
    logic [31:0] height_reg;
    longint      first_x, first_y, first_spd, first_yaw;
    longint      prev_x, prev_y, prev_spd, prev_yaw;
    int          seen_cnt;

    point_t      expected_points[$];
    int          send_idle, recv_idle;
    int          hold_off;
    int          fail_cnt, point_cnt, wp_cnt;
    longint      cycle_cnt;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("waypoint_path_upsampler_top regression: fail");
            $finish;
        end
    end

    function automatic longint lerp_round(longint a, longint b, longint step, longint f);
        longint n, mag, q;
        n = (b - a) * step;
        mag = (n < 0) ? -n : n;
        q = (mag * 2 + f) / (2 * f);
        return a + ((n < 0) ? -q : q);
    endfunction

    function automatic longint yaw_from_quat(longint qx, longint qy, longint qz, longint qw);
        longint y, x, dx, dy;
        bit [31:0] ang, r;
        y = 2 * (qw * qz + qx * qy);
        x = (longint'(1) << 28) - 2 * (qy * qy + qz * qz);
        ang = '0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            ang = 32'h80000000;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; ang += ATAN_TURN[i];
            end else begin
                x -= dx; y += dy; ang -= ATAN_TURN[i];
            end
        end
        r = (ang + 32'h8000) >> 16;
        return longint'($signed(r[15:0]));
    endfunction

    function automatic longint round_q14(longint v, bit neg);
        longint r;
        r = (v + 32768) >>> 16;
        if (neg) r = -r;
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r;
    endfunction

    task automatic half_yaw_sincos(input longint h, output longint s, output longint c);
        bit [31:0] u;
        longint z, x, y, dx, dy;
        bit neg;
        u = 32'(h & 64'h1FFFF) << 15;
        z = longint'($signed(u));
        x = 652032874;
        y = 0;
        neg = 1'b0;
        if (z > 64'sh40000000) begin
            z -= 64'sh80000000; neg = 1'b1;
        end else if (z < -64'sh40000000) begin
            z += 64'sh80000000; neg = 1'b1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_TURN[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_TURN[i]);
            end
        end
        c = round_q14(x, neg);
        s = round_q14(y, neg);
    endtask

    task automatic push_segment(longint ax, longint ay, longint aspd, longint ayaw,
                                longint bx, longint by, longint bspd, longint byaw,
                                longint f);
        longint d, h, s, c;
        point_t p;
        d = longint'($signed(16'(byaw - ayaw)));
        for (longint step = 0; step < f; step++) begin
            h = ayaw + lerp_round(0, d, step, f);
            half_yaw_sincos(h, s, c);
            p.x = 32'(lerp_round(ax, bx, step, f));
            p.y = 32'(lerp_round(ay, by, step, f));
            p.z = height_reg;
            p.qx = '0;
            p.qy = '0;
            p.qz = 16'(s);
            p.qw = 16'(c);
            p.spd = 16'(lerp_round(aspd, bspd, step, f));
            p.run_end = 1'b0;
            p.path_end = 1'b0;
            expected_points = {expected_points, p};
        end
    endtask

    task automatic predict_points(input waypoint_t w);
        longint px, py, spd, yaw, f;
        point_t p;
        px = longint'($signed(w.pos_x));
        py = longint'($signed(w.pos_y));
        spd = longint'($signed(w.speed));
        yaw = yaw_from_quat($signed(w.quat_x), $signed(w.quat_y),
                            $signed(w.quat_z), $signed(w.quat_w));
        f = factor_reg;
        if (f < 1) f = 1;
        if (f > MAX_FACTOR) f = MAX_FACTOR;
        if (f == 1 || (seen_cnt == 0 && w.final_waypoint)) begin
            p.x = w.pos_x; p.y = w.pos_y; p.z = height_reg;
            p.qx = w.quat_x; p.qy = w.quat_y; p.qz = w.quat_z; p.qw = w.quat_w;
            p.spd = w.speed;
            p.run_end = 1'b1;
            p.path_end = w.final_waypoint;
            expected_points = {expected_points, p};
        end else if (seen_cnt != 0) begin
            push_segment(prev_x, prev_y, prev_spd, prev_yaw, px, py, spd, yaw, f);
            if (w.final_waypoint) begin
                push_segment(px, py, spd, yaw, first_x, first_y, first_spd, first_yaw, f);
                expected_points[expected_points.size()-1].path_end = 1'b1;
            end
            expected_points[expected_points.size()-1].run_end = 1'b1;
        end
        if (w.final_waypoint) begin
            seen_cnt = 0;
        end else begin
            if (seen_cnt == 0) begin
                first_x = px; first_y = py; first_spd = spd; first_yaw = yaw;
                seen_cnt = 1;
            end else begin
                seen_cnt = 2;
            end
            prev_x = px; prev_y = py; prev_spd = spd; prev_yaw = yaw;
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            point_t e;
            point_cnt++;
            if (expected_points.size() == 0) begin
                $error("unexpected result beat x=%0h", m_out_x);
                fail_cnt++;
            end else begin
                e = expected_points.pop_front();
                if (m_out_x !== e.x) begin
                    $error("out_x exp %0h got %0h", e.x, m_out_x); fail_cnt++;
                end
                if (m_out_y !== e.y) begin
                    $error("out_y exp %0h got %0h", e.y, m_out_y); fail_cnt++;
                end
                if (m_out_z !== e.z) begin
                    $error("out_z exp %0h got %0h", e.z, m_out_z); fail_cnt++;
                end
                if (m_out_qx !== e.qx) begin
                    $error("out_qx exp %0h got %0h", e.qx, m_out_qx); fail_cnt++;
                end
                if (m_out_qy !== e.qy) begin
                    $error("out_qy exp %0h got %0h", e.qy, m_out_qy); fail_cnt++;
                end
                if (m_out_qz !== e.qz) begin
                    $error("out_qz exp %0h got %0h", e.qz, m_out_qz); fail_cnt++;
                end
                if (m_out_qw !== e.qw) begin
                    $error("out_qw exp %0h got %0h", e.qw, m_out_qw); fail_cnt++;
                end
                if (m_out_speed !== e.spd) begin
                    $error("out_speed exp %0h got %0h", e.spd, m_out_speed); fail_cnt++;
                end
                if (m_run_end !== e.run_end) begin
                    $error("run_end exp %0b got %0b", e.run_end, m_run_end); fail_cnt++;
                end
                if (m_path_end !== e.path_end) begin
                    $error("path_end exp %0b got %0b", e.path_end, m_path_end); fail_cnt++;
                end
            end
        end
        // long hold-off counts down here, otherwise stall at random
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send_waypoint(input waypoint_t w);
        while ($urandom_range(99) < send_idle) begin
            @(posedge aclk);
            s_valid <= 1'b0;
        end
        @(posedge aclk);
        s_valid <= 1'b1;
        {s_pos_x, s_pos_y, s_quat_x, s_quat_y, s_quat_z, s_quat_w, s_speed,
         s_final_waypoint} <= w;
        do @(posedge aclk); while (!s_ready);
        predict_points(w);
        wp_cnt++;
        s_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (expected_points.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_INTERP_FACTOR) factor_reg = val[4:0];
        else height_reg = val;
    endtask

    function automatic logic [15:0] rand_quat_part();
        int k;
        k = $urandom_range(7);
        if (k == 0) return 16'sd16384;
        if (k == 1) return -16'sd16384;
        if (k == 2) return 16'd0;
        return 16'(int'($urandom_range(32768)) - 16384);
    endfunction

    function automatic waypoint_t rand_waypoint(bit fin);
        waypoint_t w;
        w.pos_x = ($urandom_range(3) == 0) ? $urandom : 32'(int'($urandom_range(20000)) - 10000);
        w.pos_y = ($urandom_range(3) == 0) ? $urandom : 32'(int'($urandom_range(20000)) - 10000);
        w.quat_x = rand_quat_part();
        w.quat_y = rand_quat_part();
        w.quat_z = rand_quat_part();
        w.quat_w = rand_quat_part();
        w.speed = 16'($urandom);
        w.final_waypoint = fin;
        return w;
    endfunction

    function automatic waypoint_t make_wp(int x, int y, int qx, int qy, int qz, int qw,
                                          int spd, bit fin);
        waypoint_t w;
        w = '{32'(x), 32'(y), 16'(qx), 16'(qy), 16'(qz), 16'(qw), 16'(spd), fin};
        return w;
    endfunction

    task automatic test_directed();
        write_reg(REG_HEIGHT_Z, 32'h7FFFFFFF);
        // single-point path passes through at the default factor
        send_waypoint(make_wp(100, -100, 0, 0, 0, 16384, 256, 1'b1));
        // full-scale positions, yaw at +-pi, undefined atan2
        send_waypoint(make_wp(32'h7FFFFFFF, 32'h80000000, 0, 0, 16384, 0, 32767, 1'b0));
        send_waypoint(make_wp(32'h80000000, 32'h7FFFFFFF, 0, 0, -16384, 0, -32768, 1'b0));
        send_waypoint(make_wp(0, 0, 0, 8192, 8192, 0, 0, 1'b0));
        send_waypoint(make_wp(-1, 1, 16384, -16384, 16384, -16384, 1, 1'b1));
        wait_idle();
        write_reg(REG_INTERP_FACTOR, 32'd16);
        write_reg(REG_HEIGHT_Z, 32'h80000000);
        send_waypoint(make_wp(0, 0, 0, 0, 11585, 11585, 100, 1'b0));
        send_waypoint(make_wp(5000, -5000, 0, 0, -11585, 11585, -100, 1'b1));
        wait_idle();
        // zero and oversize factors, then plain passthrough
        write_reg(REG_INTERP_FACTOR, 32'd0);
        send_waypoint(make_wp(7, 8, 1, 2, 3, 4, 5, 1'b0));
        send_waypoint(make_wp(9, 10, 1, 2, 3, 4, 5, 1'b1));
        wait_idle();
        write_reg(REG_INTERP_FACTOR, 32'd31);
        send_waypoint(make_wp(-300, 300, 0, 0, 0, 16384, 50, 1'b0));
        send_waypoint(make_wp(300, -300, 0, 0, 16384, 0, -50, 1'b1));
        wait_idle();
        write_reg(REG_INTERP_FACTOR, 32'd1);
        write_reg(REG_HEIGHT_Z, 32'd0);
        send_waypoint(make_wp(1, 2, 3, 4, 5, 6, 7, 1'b0));
        send_waypoint(make_wp(-1, -2, -3, -4, -5, -6, -7, 1'b1));
        wait_idle();
        write_reg(REG_INTERP_FACTOR, 32'd2);
        send_waypoint(make_wp(10, 10, 0, 0, 0, 16384, 0, 1'b0));
        send_waypoint(make_wp(20, 30, 0, 0, 8000, 8000, 10, 1'b0));
        send_waypoint(make_wp(-20, 5, 0, 0, -8000, 8000, 20, 1'b1));
        wait_idle();
    endtask

    task automatic test_random_paths(input int n_items, input int s_idle, input int r_idle);
        int sent, len;
        logic [31:0] f;
        send_idle = s_idle;
        recv_idle = r_idle;
        sent = 0;
        while (sent < n_items) begin
            wait_idle();
            case ($urandom_range(9))
                0: f = 32'd1;
                1: f = 32'd16;
                2: f = 32'd0;
                3: f = 32'($urandom_range(31, 17));
                default: f = 32'($urandom_range(5, 2));
            endcase
            write_reg(REG_INTERP_FACTOR, f);
            write_reg(REG_HEIGHT_Z, $urandom);
            for (int b = 0; b < 30 && sent < n_items; ) begin
                len = ($urandom_range(9) == 0) ? 1 : $urandom_range(6, 2);
                for (int i = 0; i < len; i++) begin
                    send_waypoint(rand_waypoint(i == len - 1));
                    sent++;
                    b++;
                end
            end
        end
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        send_idle = 0;
        recv_idle = 0;
        write_reg(REG_INTERP_FACTOR, 32'd4);
        hold_off = 3000;
        for (int i = 0; i < 8; i++) send_waypoint(rand_waypoint(i == 7));
        wait_idle();
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        {s_pos_x, s_pos_y, s_quat_x, s_quat_y, s_quat_z, s_quat_w, s_speed,
         s_final_waypoint} = '0;
        m_ready = 1'b0;
        send_idle = 0;
        recv_idle = 0;
        hold_off = 0;
        fail_cnt = 0;
        point_cnt = 0;
        wp_cnt = 0;
        cycle_cnt = 0;
        factor_reg = 5'd5;
        height_reg = '0;
        {first_x, first_y, first_spd, first_yaw} = '0;
        {prev_x, prev_y, prev_spd, prev_yaw} = '0;
        seen_cnt = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_paths(130, 30, 53);
        test_random_paths(130, 53, 30);
        test_random_paths(130, 0, 0);
        test_output_backpressure();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_points.size() != 0) begin
            $error("%0d expected points never arrived", expected_points.size());
            fail_cnt++;
        end
        $display("covered %0d waypoints and %0d path points across factor, height and",
                 wp_cnt, point_cnt);
        $display("idle mixes, including a long output hold-off");
        if (fail_cnt == 0) begin
            $display("waypoint_path_upsampler_top regression: pass");
        end else begin
            $display("waypoint_path_upsampler_top regression: fail");
        end
        $finish;
    end

endmodule
